>>> design/pdd_pkg.sv
// ----------------------------------------------------------------------------
// Pose detection decode package
// Shared constants and types for the pose output decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package pdd_pkg;
  localparam int unsigned DefMaxKeypoints = 32;
  localparam int unsigned DefMaxClasses = 16;
  localparam int unsigned ValW = 24;
  localparam int unsigned BoxW = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegNetWidth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNetHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNumKeypoints = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHasClass = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNumClasses = 3'd4;

  typedef struct packed {
    logic        func;
    logic [23:0] value;
    logic [3:0]  class_slot;
    logic        first_of_tensor;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  class_id;
    logic [23:0] confidence;
    logic [19:0] box_left;
    logic [19:0] box_top;
    logic [19:0] box_width;
    logic [19:0] box_height;
    logic [4:0]  keypoint_index;
    logic [23:0] keypoint_x;
    logic [23:0] keypoint_y;
    logic [23:0] keypoint_score;
    logic        last;
  } out_item_t;

  // Work item passed from the front to the back part.
  typedef struct packed {
    logic        kind;
    logic [3:0]  class_id;
    logic [23:0] confidence;
    logic [19:0] box_left;
    logic [19:0] box_top;
    logic [19:0] box_width;
    logic [19:0] box_height;
    logic [4:0]  keypoint_index;
    logic [23:0] kx;
    logic [23:0] ky;
    logic [23:0] keypoint_score;
    logic        last;
  } job_t;
endpackage
`default_nettype wire

>>> design/pdd_stream_if.sv
// ----------------------------------------------------------------------------
// Pose detection decode stream interface
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface pdd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/pose_detection_decode_unit.sv
// ----------------------------------------------------------------------------
// Pose detection decode unit
// Decodes pose detector rows into box and keypoint items.
// ----------------------------------------------------------------------------
// Input items are taken one per cycle while the four-entry job queue has room.
// A box item passes through the queue without division; a keypoint item is
// normalized by two 42-step serial divisions, x then y, in one divider.
// Reset clears the thresholds and the queue; the config registers go to
// 640, 640, 17, 1, 1.
`default_nettype none
module pose_detection_decode_unit
  import pdd_pkg::*;
#(
  parameter int unsigned MaxKeypoints = DefMaxKeypoints,
  parameter int unsigned MaxClasses = DefMaxClasses
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  pdd_stream_if.sink              in_s,
  pdd_stream_if.source            out_s
);
  logic jv, jr;
  job_t job;
  pdd_front #(.MaxKeypoints(MaxKeypoints), .MaxClasses(MaxClasses)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_s,
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job));
  pdd_back u_back (.clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr),
    .job_i(job), .out_s);
endmodule
`default_nettype wire

>>> design/pdd_div.sv
// ----------------------------------------------------------------------------
// Pose detection decode divider
// Signed restoring divider, one quotient bit per cycle, truncating, saturating.
// ----------------------------------------------------------------------------
`default_nettype none
module pdd_div
  import pdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [25:0] num_i,
  input  wire logic [19:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [23:0]      quo_o
);
  localparam int unsigned QW = 42;
  logic [QW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [19:0]   den_q;
  logic          neg_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q;
  logic [QW:0]   trial;
  logic [QW-1:0] shifted;
  logic [QW:0]   sq;

  assign shifted = {rem_q[QW-2:0], quo_q[QW-1]};
  assign trial = {1'b0, shifted} - {{(QW-19){1'b0}}, den_q};
  always_comb begin
    rem_d = trial[QW] ? shifted : trial[QW-1:0];
    quo_d = {quo_q[QW-2:0], ~trial[QW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(QW);
      end else if (busy_q) begin
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= {(num_i[25] ? 26'(-num_i) : num_i), 16'd0};
      den_q <= den_i;
      neg_q <= num_i[25];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    sq = neg_q ? (QW+1)'(-{1'b0, quo_q}) : {1'b0, quo_q};
    if (!neg_q && quo_q > 42'h7FFFFF) quo_o = 24'h7FFFFF;
    else if (neg_q && quo_q > 42'h800000) quo_o = 24'h800000;
    else quo_o = sq[23:0];
  end
  assign busy_o = busy_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

>>> design/pdd_front.sv
// ----------------------------------------------------------------------------
// Pose detection decode front end
// Tracks columns, judges rows, clips boxes and issues jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module pdd_front
  import pdd_pkg::*;
#(
  parameter int unsigned MaxKeypoints = DefMaxKeypoints,
  parameter int unsigned MaxClasses = DefMaxClasses
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  pdd_stream_if.sink            in_s,
  output logic                  job_valid_o,
  input  wire logic             job_ready_i,
  output job_t                  job_o
);
  localparam int unsigned ThW = (MaxClasses > 1) ? $clog2(MaxClasses) : 1;
  logic [12:0] nw_q, nh_q;
  logic [5:0]  nk_q;
  logic        hc_q;
  logic [4:0]  nc_q;
  logic [6:0]  col_q;
  logic        kept_q;
  logic [23:0] x1_q, y1_q, x2_q, y2_q, conf_q, kx_q, ky_q;
  logic [3:0]  cls_q;
  logic [19:0] bl_q, bt_q, bw_q, bh_q;
  logic [23:0] th_q [MaxClasses];

  logic [6:0]  k, off, len, c, j, jj;
  logic [13:0] jm;
  logic [4:0]  idx;
  logic [1:0]  r;
  logic [8:0]  ncl;
  logic [23:0] v;
  logic [23:0] cv, pos, conf;
  logic signed [16:0] clsv;
  logic [19:0] lx, ly, nl, nt, nwd, nht;
  logic        judge, keep, emit_box, emit_kp;
  logic        ok_cls;
  logic [23:0] thr;

  function automatic logic [19:0] lim(input logic [12:0] n);
    logic [20:0] t;
    begin
      t = (n == 13'd0) ? 21'd0 : {n - 13'd1, 8'd0};
      lim = (t > 21'hFFFFF) ? 20'hFFFFF : t[19:0];
    end
  endfunction

  function automatic logic [19:0] clp(input logic signed [24:0] a,
                                      input logic [19:0] hi);
    begin
      if (a < 0) clp = '0;
      else if (a > $signed({5'd0, hi})) clp = hi;
      else clp = a[19:0];
    end
  endfunction

  assign v = in_s.data.value;
  always_comb begin
    k = (nk_q == 6'd0) ? 7'd1 : ((32'(nk_q) > MaxKeypoints) ?
        7'(MaxKeypoints) : {1'b0, nk_q});
    off = hc_q ? 7'd6 : 7'd5;
    len = off + 7'(3 * 32'(k));
    c = in_s.data.first_of_tensor ? 7'd0 : col_q;
    if (c >= len) c = 7'd0;
    ncl = (nc_q == 5'd0) ? 9'd1 : ((32'(nc_q) > MaxClasses) ?
          9'(MaxClasses) : {4'd0, nc_q});
    judge = (c == 7'd4 && !hc_q) || (c == 7'd5 && hc_q);
    conf = (c == 7'd4) ? v : conf_q;
    cv = (c == 7'd5) ? v : 24'd0;
    pos = cv[23] ? 24'(-cv) : cv;
    clsv = cv[23] ? -$signed({1'b0, pos[23:8]}) : $signed({1'b0, pos[23:8]});
    ok_cls = !clsv[16] && (clsv < $signed({8'd0, ncl}));
    thr = th_q[ThW'(clsv)];
    lx = lim(nw_q);
    ly = lim(nh_q);
    nl = clp({x1_q[23], x1_q}, lx);
    nt = clp({y1_q[23], y1_q}, ly);
    nwd = clp($signed({x2_q[23], x2_q}) - $signed({x1_q[23], x1_q}), lx);
    nht = clp($signed({y2_q[23], y2_q}) - $signed({y1_q[23], y1_q}), ly);
    keep = judge && ok_cls && !($signed(conf) < $signed(thr)) &&
           nwd >= 20'd256 && nht >= 20'd256;
    j = c - off;
    jm = 14'(j) * 14'd43;
    idx = jm[11:7];
    jj = j - 7'(3 * 32'(idx));
    r = jj[1:0];
  end

  logic is_val, fire;
  assign is_val = in_s.valid && !in_s.data.func;
  assign emit_box = is_val && keep;
  assign emit_kp = is_val && c >= off && r == 2'd2 && kept_q && c != 7'd0;
  assign in_s.ready = job_ready_i;
  assign fire = in_s.valid && in_s.ready;
  assign job_valid_o = emit_box || emit_kp;

  always_comb begin
    job_o = '0;
    job_o.kind = emit_kp;
    job_o.class_id = emit_box ? 4'(clsv) : cls_q;
    job_o.confidence = conf;
    job_o.box_left = emit_box ? nl : bl_q;
    job_o.box_top = emit_box ? nt : bt_q;
    job_o.box_width = emit_box ? nwd : bw_q;
    job_o.box_height = emit_box ? nht : bh_q;
    if (emit_kp) begin
      job_o.keypoint_index = idx;
      job_o.kx = kx_q;
      job_o.ky = ky_q;
      job_o.keypoint_score = v;
      job_o.last = (7'(idx) + 7'd1 == k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nw_q <= 13'd640; nh_q <= 13'd640; nk_q <= 6'd17; hc_q <= 1'b1;
      nc_q <= 5'd1; col_q <= '0; kept_q <= 1'b0; cls_q <= '0;
      conf_q <= '0; x1_q <= '0; y1_q <= '0; x2_q <= '0; y2_q <= '0;
      kx_q <= '0; ky_q <= '0; bl_q <= '0; bt_q <= '0; bw_q <= '0; bh_q <= '0;
      for (int i = 0; i < MaxClasses; i++) th_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegNetWidth: nw_q <= cfg_data_i;
          RegNetHeight: nh_q <= cfg_data_i;
          RegNumKeypoints: nk_q <= cfg_data_i[5:0];
          RegHasClass: hc_q <= cfg_data_i[0];
          RegNumClasses: nc_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (fire && in_s.data.func) begin
        if (32'(in_s.data.class_slot) < MaxClasses)
          th_q[ThW'(in_s.data.class_slot)] <= v;
      end else if (fire) begin
        col_q <= (c + 7'd1 >= len) ? 7'd0 : c + 7'd1;
        if (c == 7'd0) kept_q <= 1'b0;
        case (c)
          7'd0: x1_q <= v;
          7'd1: y1_q <= v;
          7'd2: x2_q <= v;
          7'd3: y2_q <= v;
          7'd4: conf_q <= v;
          default: ;
        endcase
        if (judge) begin
          kept_q <= keep;
          if (ok_cls && !($signed(conf) < $signed(thr))) begin
            cls_q <= 4'(clsv);
            bl_q <= nl; bt_q <= nt; bw_q <= nwd; bh_q <= nht;
          end
        end
        if (c >= off && r == 2'd0) kx_q <= v;
        if (c >= off && r == 2'd1) ky_q <= v;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/pdd_back.sv
// ----------------------------------------------------------------------------
// Pose detection decode back end
// Queues jobs, normalizes keypoints with a shared divider, drives results.
// ----------------------------------------------------------------------------
`default_nettype none
module pdd_back
  import pdd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  pdd_stream_if.source out_s
);
  localparam int unsigned Depth = 4;
  job_t        fifo_q [Depth];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic        push, pop;
  job_t        head;
  logic [1:0]  st_q;
  localparam logic [1:0] StIdle = 2'd0, StDivX = 2'd1, StDivY = 2'd2,
                         StOut = 2'd3;
  logic        dstart, dbusy, ddone;
  logic [23:0] dq, qx_q, qy_q;
  logic [25:0] dnum;
  logic [19:0] dden;

  assign head = fifo_q[rp_q];
  assign job_ready_o = cnt_q != 3'(Depth);
  assign push = job_valid_i && job_ready_o;
  assign pop = st_q == StOut && out_s.ready;

  assign dstart = (st_q == StIdle && cnt_q != 3'd0 && head.kind) ||
                  (st_q == StDivX && ddone);
  always_comb begin
    if (st_q == StIdle) begin
      dnum = 26'($signed({head.kx[23], head.kx}) - $signed({5'd0, head.box_left}));
      dden = head.box_width;
    end else begin
      dnum = 26'($signed({head.ky[23], head.ky}) - $signed({5'd0, head.box_top}));
      dden = head.box_height;
    end
  end

  pdd_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
                 .busy_o(dbusy), .done_o(ddone), .quo_o(dq));

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= job_i;
    if (st_q == StDivX && ddone) qx_q <= dq;
    if (st_q == StDivY && ddone) qy_q <= dq;
    if (st_q == StIdle && cnt_q != 3'd0 && !head.kind) begin
      qx_q <= '0; qy_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; st_q <= StIdle;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
      case (st_q)
        StIdle: if (cnt_q != 3'd0 && !dbusy) st_q <= head.kind ? StDivX : StOut;
        StDivX: if (ddone) st_q <= StDivY;
        StDivY: if (ddone) st_q <= StOut;
        StOut: if (out_s.ready) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_s.valid = st_q == StOut;
  always_comb begin
    out_s.data.kind = head.kind;
    out_s.data.class_id = head.class_id;
    out_s.data.confidence = head.confidence;
    out_s.data.box_left = head.box_left;
    out_s.data.box_top = head.box_top;
    out_s.data.box_width = head.box_width;
    out_s.data.box_height = head.box_height;
    out_s.data.keypoint_index = head.keypoint_index;
    out_s.data.keypoint_x = qx_q;
    out_s.data.keypoint_y = qy_q;
    out_s.data.keypoint_score = head.keypoint_score;
    out_s.data.last = head.last;
  end
endmodule
`default_nettype wire

>>> design/pdd_checker.sv
// ----------------------------------------------------------------------------
// Pose detection decode checker
// Port-level assertions bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pdd_checker
  import pdd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input out_item_t out_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)) else $error("hold");
  a_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.kind |-> !out_data_i.last && out_data_i.keypoint_x == 24'd0)
    else $error("box fields");
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.box_width >= 20'd256 && out_data_i.box_height >= 20'd256)
    else $error("size");
endmodule

bind pose_detection_decode_unit pdd_checker u_chk (.clk_i, .rst_ni,
  .out_valid_i(out_s.valid), .out_ready_i(out_s.ready), .out_data_i(out_s.data));
`default_nettype wire
